// ===== src/nzmd_pkg.sv =====
// ----------------------------------------------------------------------------
// nzmd_pkg
// Shared types, widths and codes for the nearest zone match and debounce core.
// ----------------------------------------------------------------------------
package nzmd_pkg;

    // Table size and coordinate width
    localparam int MAX_ZONES  = 32;
    localparam int COORD_BITS = 24;

    // Zone index and zone counter widths
    localparam int ZI_W  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CNT_W = $clog2(MAX_ZONES + 1);

    // Field widths fixed by the interface
    localparam int SLOT_W = 5;
    localparam int DIST_W = 25;
    localparam int HIT_W  = 16;
    localparam int ZC_W   = 6;

    // Distance arithmetic: |d| at or above 2^FAR_BITS clamps s to 2^(2*FAR_BITS+1)
    localparam int FAR_BITS = 25;
    localparam int ABS_W    = COORD_BITS + 1;
    localparam int SQ_W     = 2 * FAR_BITS;
    localparam int S_W      = 2 * FAR_BITS + 2;
    localparam int ROOT_W   = S_W / 2;
    localparam logic [63:0]      FAR_LIMIT = 64'd1 << FAR_BITS;
    localparam logic [S_W-1:0]   S_CLAMP   = {1'b1, {(S_W-1){1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_HITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSE_OUT_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_ONLY_ONCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT      = 3'd4;

    // Request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POSE = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic [SLOT_W-1:0]             zone_slot;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
    } nzmd_in_t;

    typedef struct packed {
        logic              match_ok;
        logic              zone_found;
        logic [SLOT_W-1:0] best_zone;
        logic [DIST_W-1:0] best_distance;
        logic              emit_initial_pose;
    } nzmd_out_t;

    typedef struct packed {
        logic [DIST_W-1:0] accept_radius;
        logic [HIT_W-1:0]  required_hits;
        logic              pose_out_enable;
        logic              emit_only_once;
        logic [ZC_W-1:0]   zone_count;
    } nzmd_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic            accept_load;
        logic            accept_pose;
        logic            rd_en;
        logic [ZI_W-1:0] rd_addr;
        logic            rd_last;
        logic            hit_update;
        logic            sqrt_start;
        logic            out_load;
        logic            none;
    } nzmd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic sqrt_done;
    } nzmd_sts_t;

endpackage

// ===== src/nzmd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// nzmd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module nzmd_cfg_regs
    import nzmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output nzmd_cfg_t             cfg
);

    nzmd_cfg_t cfg_reg;
    nzmd_cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ACCEPT_RADIUS:   cfg_next.accept_radius   = cfg_wdata[DIST_W-1:0];
                REG_REQUIRED_HITS:   cfg_next.required_hits   = cfg_wdata[HIT_W-1:0];
                REG_POSE_OUT_ENABLE: cfg_next.pose_out_enable = cfg_wdata[0];
                REG_EMIT_ONLY_ONCE:  cfg_next.emit_only_once  = cfg_wdata[0];
                REG_ZONE_COUNT:      cfg_next.zone_count      = cfg_wdata[ZC_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accept_radius   <= DIST_W'(512);
            cfg_reg.required_hits   <= HIT_W'(10);
            cfg_reg.pose_out_enable <= 1'b1;
            cfg_reg.emit_only_once  <= 1'b1;
            cfg_reg.zone_count      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/nzmd_isqrt.sv =====
// ----------------------------------------------------------------------------
// nzmd_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nzmd_isqrt
    import nzmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [S_W-1:0]    operand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam logic [S_W-1:0] BIT_TOP = S_W'(1) << (S_W - 2);

    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    logic [S_W-1:0] rem_reg;
    logic [S_W-1:0] rem_next;
    logic [S_W-1:0] res_reg;
    logic [S_W-1:0] res_next;
    logic [S_W-1:0] bit_reg;
    logic [S_W-1:0] bit_next;
    logic [S_W-1:0] trial;
    logic           take;

    // One restoring step: try res + bit against the remainder
    always_comb
    begin
        trial     = res_reg + bit_reg;
        take      = (rem_reg >= trial);
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = operand;
            res_next  = '0;
            bit_next  = BIT_TOP;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // last step when the trial bit is at weight one
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== src/nzmd_datapath.sv =====
// ----------------------------------------------------------------------------
// nzmd_datapath
// Zone table, distance pipeline, nearest search, debounce state and result.
// ----------------------------------------------------------------------------
module nzmd_datapath
    import nzmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  nzmd_cfg_t cfg,
    input  nzmd_in_t  in_data,
    input  nzmd_cmd_t cmd,
    output nzmd_sts_t sts,
    output nzmd_out_t out_data
);

    // Zone table: {x, y} per entry
    logic [2*COORD_BITS-1:0] zone_mem [MAX_ZONES];
    logic [2*COORD_BITS-1:0] rd_q_reg;
    logic                    slot_ok;
    logic [ZI_W-1:0]         wr_addr;

    // Pose and radius held for the scan
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [2*DIST_W-1:0]          rsq_reg;

    // Pipeline control
    logic            p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic            p1_last_reg,  p2_last_reg,  p3_last_reg,  p4_last_reg;
    logic [ZI_W-1:0] p1_idx_reg,   p2_idx_reg,   p3_idx_reg,   p4_idx_reg;
    logic            scan_done_reg;

    // Pipeline payload
    logic signed [COORD_BITS-1:0] cx, cy;
    logic signed [ABS_W-1:0]      dx, dy;
    logic [ABS_W-1:0]             ax, ay;
    logic                         far;
    logic [FAR_BITS-1:0]          ax_reg, ay_reg;
    logic                         far2_reg, far3_reg;
    logic [SQ_W-1:0]              sqx_reg, sqy_reg;
    logic [S_W-1:0]               s_reg;

    // Nearest search
    logic [S_W-1:0]  best_s_reg;
    logic [ZI_W-1:0] best_idx_reg;

    // Debounce state
    logic [ZI_W-1:0]  last_zone_reg, last_zone_next;
    logic [HIT_W-1:0] hit_reg, hit_next;
    logic             pose_sent_reg, pose_sent_next;
    logic             ok_reg, ok_next;
    logic             emit_reg, emit_next;
    logic             radius_hit;

    // Square root
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic [DIST_W-1:0] dist_sat;

    nzmd_out_t out_reg;

    // Table write and registered scan read
    assign slot_ok = (32'(in_data.zone_slot) < MAX_ZONES);
    assign wr_addr = ZI_W'(in_data.zone_slot);

    always_ff @(posedge clk)
    begin
        if (cmd.accept_load && slot_ok)
        begin
            zone_mem[wr_addr] <= {in_data.coord_x, in_data.coord_y};
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= zone_mem[cmd.rd_addr];
        end
    end

    // Pose capture and squared radius
    always_ff @(posedge clk)
    begin
        if (cmd.accept_pose)
        begin
            px_reg  <= in_data.coord_x;
            py_reg  <= in_data.coord_y;
            rsq_reg <= cfg.accept_radius * cfg.accept_radius;
        end
    end

    // Stage 1: difference, magnitude and far check
    always_comb
    begin
        cx  = signed'(rd_q_reg[2*COORD_BITS-1:COORD_BITS]);
        cy  = signed'(rd_q_reg[COORD_BITS-1:0]);
        dx  = ABS_W'(px_reg) - ABS_W'(cx);
        dy  = ABS_W'(py_reg) - ABS_W'(cy);
        ax  = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        ay  = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
        far = (64'(ax) >= FAR_LIMIT) || (64'(ay) >= FAR_LIMIT);
    end

    // Pipeline control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_last_reg   <= 1'b0;
            p3_last_reg   <= 1'b0;
            p4_last_reg   <= 1'b0;
            scan_done_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= cmd.rd_en;
            p1_last_reg   <= cmd.rd_en && cmd.rd_last;
            p2_valid_reg  <= p1_valid_reg;
            p2_last_reg   <= p1_last_reg;
            p3_valid_reg  <= p2_valid_reg;
            p3_last_reg   <= p2_last_reg;
            p4_valid_reg  <= p3_valid_reg;
            p4_last_reg   <= p3_last_reg;
            scan_done_reg <= p4_valid_reg && p4_last_reg;
        end
    end

    // Pipeline payload: magnitudes, squares, sum, running minimum
    always_ff @(posedge clk)
    begin
        p1_idx_reg <= cmd.rd_addr;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        p4_idx_reg <= p3_idx_reg;

        ax_reg   <= FAR_BITS'(64'(ax));
        ay_reg   <= FAR_BITS'(64'(ay));
        far2_reg <= far;

        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        far3_reg <= far2_reg;

        s_reg <= far3_reg ? S_CLAMP : (S_W'(sqx_reg) + S_W'(sqy_reg));

        // first entry seeds; strict less keeps the lowest index on ties
        if (p4_valid_reg && ((p4_idx_reg == '0) || (s_reg < best_s_reg)))
        begin
            best_s_reg   <= s_reg;
            best_idx_reg <= p4_idx_reg;
        end
    end

    // Hit count debounce and initial pose flag
    assign radius_hit = (best_s_reg <= S_W'(rsq_reg));

    always_comb
    begin
        last_zone_next = last_zone_reg;
        hit_next       = hit_reg;
        pose_sent_next = pose_sent_reg;
        ok_next        = ok_reg;
        emit_next      = emit_reg;
        if (cmd.hit_update)
        begin
            if (radius_hit)
            begin
                if ((hit_reg != '0) && (last_zone_reg == best_idx_reg))
                begin
                    if (hit_reg != '1)
                    begin
                        hit_next = hit_reg + HIT_W'(1);
                    end
                end
                else
                begin
                    last_zone_next = best_idx_reg;
                    hit_next       = HIT_W'(1);
                end
            end
            else
            begin
                last_zone_next = '0;
                hit_next       = '0;
            end
            ok_next   = (hit_next >= cfg.required_hits);
            emit_next = ok_next && cfg.pose_out_enable
                        && (!cfg.emit_only_once || !pose_sent_reg);
            if (emit_next)
            begin
                pose_sent_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_zone_reg <= '0;
            hit_reg       <= '0;
            pose_sent_reg <= 1'b0;
        end
        else
        begin
            last_zone_reg <= last_zone_next;
            hit_reg       <= hit_next;
            pose_sent_reg <= pose_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        emit_reg <= emit_next;
    end

    // Distance root
    nzmd_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (best_s_reg),
        .done    (sqrt_done),
        .root    (root)
    );

    assign dist_sat = (root > ROOT_W'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.none)
            begin
                out_reg.match_ok          <= 1'b0;
                out_reg.zone_found        <= 1'b0;
                out_reg.best_zone         <= '0;
                out_reg.best_distance     <= DIST_MAX;
                out_reg.emit_initial_pose <= 1'b0;
            end
            else
            begin
                out_reg.match_ok          <= ok_reg;
                out_reg.zone_found        <= 1'b1;
                out_reg.best_zone         <= SLOT_W'(best_idx_reg);
                out_reg.best_distance     <= dist_sat;
                out_reg.emit_initial_pose <= emit_reg;
            end
        end
    end

    assign out_data      = out_reg;
    assign sts.scan_done = scan_done_reg;
    assign sts.sqrt_done = sqrt_done;

endmodule

// ===== src/nzmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// nzmd_ctrl
// Sequencer: input transfers, zone scan, debounce update, root, result.
// ----------------------------------------------------------------------------
module nzmd_ctrl
    import nzmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  nzmd_cfg_t cfg,
    input  logic      in_valid,
    input  logic      in_req_type,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  nzmd_sts_t sts,
    output nzmd_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SQRT   = 6'b010000,
        S_FINISH = 6'b100000
    } ctrl_state_t;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             none_reg, none_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] n_eff;
    logic             accept;
    logic             out_free;

    // Active zone count, clamped to the table size
    assign n_eff = (32'(cfg.zone_count) > MAX_ZONES) ? CNT_W'(MAX_ZONES)
                                                      : CNT_W'(cfg.zone_count);

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        none_next      = none_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd             = '0;
        cmd.accept_load = accept && (in_req_type == REQ_LOAD);
        cmd.accept_pose = accept && (in_req_type == REQ_POSE);
        cmd.rd_addr     = cnt_reg[ZI_W-1:0];
        cmd.rd_last     = (cnt_reg == (n_reg - CNT_W'(1)));
        cmd.none        = none_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept_pose)
                begin
                    n_next    = n_eff;
                    cnt_next  = '0;
                    none_next = (n_eff == '0);
                    state_next = (n_eff == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one table read per cycle
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cmd.rd_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.hit_update = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait until the result register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            none_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            none_reg      <= none_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/nearest_zone_match_debounce_core.sv =====
// ----------------------------------------------------------------------------
// nearest_zone_match_debounce_core
// A pose reads the N active zones, one table read per cycle, through a
// 5-stage distance pipeline and a 26-step square root; with no zones it goes
// straight to the result. Loads are taken one per cycle while no pose is in
// progress; a pose holds off the input until its result is loaded, and the
// result register lets the next transfer in.
// Reset clears control, debounce state and configuration registers; the zone
// table holds nothing valid until loaded.
// ----------------------------------------------------------------------------
module nearest_zone_match_debounce_core
    import nzmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  nzmd_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nzmd_out_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    nzmd_cfg_t cfg;
    nzmd_cmd_t cmd;
    nzmd_sts_t sts;

    // Configuration registers
    nzmd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer
    nzmd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_req_type (in_data.req_type),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Datapath
    nzmd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    // A new result never overwrites one still waiting for transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register loaded while holding a pending result");

    // The scan is complete only once table reads have stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.scan_done |-> !cmd.rd_en)
        else $error("scan reported done while reads still issue");

    // After a pose transfer the block is busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_data.req_type == REQ_POSE)) |=> in_stall)
        else $error("pose accepted but input not held off");

endmodule
